// ===== hdl/pcwa_pkg.sv =====
// Package for the path curvature window average block.
// Holds the configuration register width and its reset value; no dependencies.
`timescale 1ns / 1ps

package pcwa_pkg;

    // Width of the half window register and its value after reset.
    localparam int HALF_WINDOW_W = 5;
    localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RESET = 5'd10;

endpackage

// ===== hdl/path_curvature_window_average_top.sv =====
// Windowed mean of path curvature: sample ring, running sum and a single bit-serial divider.
// Depends on pcwa_pkg for the half window register constants.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/s_axis_tready tdata: curvature; tlast: last_sample
// m_axis    out        m_axis_tvalid/m_axis_tready tdata: mean_curvature; tlast: last_result
// cfg       in         cfg_we                      cfg_wdata: half_window
//
// One beat is taken at a time; s_axis_tready is high only while the sequencer is idle.
// Per input beat: the accepting state, one trim step for each old sample dropped from the
// window, then the write.
// Per result: the emit state, a trim step per dropped sample, the divider start, the
// bit-serial divider over all SUM_W bits of the sum, then the output state.
// A result waits in the output register; a stalled m_axis holds the sequencer in its
// output state. rst_n clears all control state; the ring memory needs no clearing.
module path_curvature_window_average_top #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int RING_DEPTH      = 34,
    parameter int SAMPLE_WIDTH    = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pcwa_pkg::HALF_WINDOW_W-1:0]     cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Bits from the lowest: curvature, then zero fill.
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Bits from the lowest: mean_curvature, then zero fill.
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int H_LIMIT  = (MAX_HALF_WINDOW < (RING_DEPTH - 2) / 2) ?
                              MAX_HALF_WINDOW : (RING_DEPTH - 2) / 2;
    localparam int SEEN_CAP = 2 * H_LIMIT + 2;
    localparam int CNT_W    = $clog2(SEEN_CAP + 1);
    localparam int KW       = CNT_W + 1;
    localparam int SUM_W    = SAMPLE_WIDTH + $clog2(SEEN_CAP);
    localparam int AW       = $clog2(RING_DEPTH);
    localparam int PW       = AW + 2;
    localparam int DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int DC_W     = $clog2(SUM_W + 1);
    localparam int CW       = pcwa_pkg::HALF_WINDOW_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIM,
        S_TRIM_SUB,
        S_WRITE,
        S_EMIT,
        S_DIV_START,
        S_DIV,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             half_window_reg;
    logic [CNT_W-1:0]          h_reg;
    logic [SAMPLE_WIDTH-1:0]   sample_reg;
    logic                      last_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          gap_reg;
    logic [CNT_W-1:0]          seen_reg;
    logic [CNT_W-1:0]          m_reg;
    logic [CNT_W-1:0]          d_reg;
    logic [KW-1:0]             keep_reg;
    logic                      emit_phase_reg;
    logic [AW-1:0]             wp_reg;
    logic [SAMPLE_WIDTH-1:0]   rd_data_reg;
    logic [CNT_W-1:0]          div_rem_reg;
    logic [SUM_W-1:0]          div_quo_reg;
    logic [DC_W-1:0]           div_cnt_reg;
    logic                      neg_reg;
    logic                      out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]   out_data_reg;
    logic                      out_last_reg;

    logic [SAMPLE_WIDTH-1:0]   ring_mem [RING_DEPTH];

    logic [CNT_W-1:0]          h_eff;
    logic [PW-1:0]             rd_pos;
    logic [AW-1:0]             rd_addr;
    logic                      ring_we;
    logic signed [SUM_W-1:0]   rd_ext;
    logic signed [SUM_W-1:0]   in_ext;
    logic [KW-1:0]             emit_span;
    logic [KW-1:0]             emit_keep;
    logic [SUM_W-1:0]          sum_mag;
    logic [CNT_W:0]            rem_shift;
    logic                      rem_ge;
    logic [SUM_W-1:0]          quo_signed;
    logic                      out_free;

    // A zero half window acts as one; above MAX_HALF_WINDOW or ring capacity it is clamped.
    always_comb
    begin
        if (half_window_reg == '0)
            h_eff = CNT_W'(1);
        else if (int'(half_window_reg) > H_LIMIT)
            h_eff = CNT_W'(H_LIMIT);
        else
            h_eff = CNT_W'(half_window_reg);
    end

    // The oldest window sample is gap_reg beats behind the write pointer.
    always_comb
    begin
        rd_pos = PW'(wp_reg) + PW'(RING_DEPTH) - PW'(gap_reg);
        if (rd_pos >= PW'(RING_DEPTH))
            rd_pos = rd_pos - PW'(RING_DEPTH);
    end
    assign rd_addr = rd_pos[AW-1:0];
    assign ring_we = (state_reg == S_WRITE);

    assign rd_ext = {{(SUM_W-SAMPLE_WIDTH){rd_data_reg[SAMPLE_WIDTH-1]}}, rd_data_reg};
    assign in_ext = {{(SUM_W-SAMPLE_WIDTH){sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};

    assign emit_span = KW'(d_reg) + KW'(h_reg) + KW'(2);
    assign emit_keep = (emit_span > KW'(seen_reg)) ? KW'(seen_reg) : emit_span;

    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_shift  = {div_rem_reg, div_quo_reg[SUM_W-1]};
    assign rem_ge     = (rem_shift >= {1'b0, gap_reg});
    assign quo_signed = neg_reg ? SUM_W'(-div_quo_reg) : div_quo_reg;
    assign out_free   = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wp_reg] <= sample_reg;
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            half_window_reg <= pcwa_pkg::HALF_WINDOW_RESET;
            h_reg           <= '0;
            sample_reg      <= '0;
            last_reg        <= 1'b0;
            sum_reg         <= '0;
            gap_reg         <= '0;
            seen_reg        <= '0;
            m_reg           <= '0;
            d_reg           <= '0;
            keep_reg        <= '0;
            emit_phase_reg  <= 1'b0;
            wp_reg          <= '0;
            div_rem_reg     <= '0;
            div_quo_reg     <= '0;
            div_cnt_reg     <= '0;
            neg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                half_window_reg <= cfg_wdata;
            // In the output state a departing beat is replaced by the next one below.
            if (out_valid_reg && m_axis_tready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        sample_reg     <= s_axis_tdata[SAMPLE_WIDTH-1:0];
                        last_reg       <= s_axis_tlast;
                        h_reg          <= h_eff;
                        m_reg          <= seen_reg;
                        keep_reg       <= (KW'(h_eff) << 1) | KW'(1);
                        emit_phase_reg <= 1'b0;
                        state_reg      <= S_TRIM;
                    end
                end
                S_TRIM:
                begin
                    if (KW'(gap_reg) > keep_reg)
                        state_reg <= S_TRIM_SUB;
                    else if (emit_phase_reg)
                        state_reg <= S_DIV_START;
                    else
                        state_reg <= S_WRITE;
                end
                S_TRIM_SUB:
                begin
                    sum_reg   <= sum_reg - rd_ext;
                    gap_reg   <= gap_reg - CNT_W'(1);
                    state_reg <= S_TRIM;
                end
                S_WRITE:
                begin
                    wp_reg  <= (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    sum_reg <= sum_reg + in_ext;
                    gap_reg <= gap_reg + CNT_W'(1);
                    if (seen_reg < CNT_W'(SEEN_CAP))
                        seen_reg <= seen_reg + CNT_W'(1);
                    // The first result lies h beats behind the new sample; the last beat
                    // of a short path starts its flush at the oldest sample instead.
                    if (m_reg >= h_reg)
                    begin
                        d_reg     <= h_reg;
                        state_reg <= S_EMIT;
                    end
                    else if (last_reg)
                    begin
                        d_reg     <= m_reg;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    keep_reg       <= emit_keep;
                    emit_phase_reg <= 1'b1;
                    state_reg      <= S_TRIM;
                end
                S_DIV_START:
                begin
                    neg_reg     <= sum_reg[SUM_W-1];
                    div_quo_reg <= sum_mag;
                    div_rem_reg <= '0;
                    div_cnt_reg <= DC_W'(SUM_W);
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_rem_reg <= CNT_W'(rem_ge ? (rem_shift - {1'b0, gap_reg}) : rem_shift);
                    div_quo_reg <= {div_quo_reg[SUM_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg - DC_W'(1);
                    if (div_cnt_reg == DC_W'(1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= (gap_reg == '0) ? '0 : quo_signed[SAMPLE_WIDTH-1:0];
                        out_last_reg  <= last_reg && (d_reg == '0);
                        if (last_reg && (d_reg != '0))
                        begin
                            d_reg     <= d_reg - CNT_W'(1);
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            if (last_reg)
                            begin
                                sum_reg  <= '0;
                                gap_reg  <= '0;
                                seen_reg <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;

    // The window never holds more samples than the path has delivered.
    assert property (@(posedge clk) disable iff (!rst_n) gap_reg <= seen_reg)
        else $error("window count exceeds samples seen");

    // An empty window carries no sum.
    assert property (@(posedge clk) disable iff (!rst_n) (gap_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero with empty window");

    // A new result is only loaded from the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output state");

endmodule
